### design/cd_pkg.sv
// cd_pkg: shared constants and codes for the circular deque block.
// No dependencies; imported by circular_deque_top.
package cd_pkg;

  localparam int CD_DEPTH      = 8;
  localparam int CD_DATA_WIDTH = 32;
  localparam int FIELD_W       = 32;
  localparam int COUNT_W       = 4;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 104;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_FILL
  } state_t;

endpackage

### design/cd_ram.sv
// cd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/circular_deque_top.sv
// Circular deque: stream interface, control, and the front/rear word cache.
// Depends on cd_pkg and cd_ram.
//
// Usage:
//   Input stream (in_*): one word per operation; in_tdata holds the operation
//   code in the low two bits and the push value above it. Output stream
//   (out_*): exactly one word per accepted operation, in order, carrying the
//   popped value, status, front and rear values, empty/full flags and count.
//   Results: pushes, refused operations and pops that empty the deque have
//   their result registered in the cycle after acceptance; a pop that leaves
//   entries takes longer, because the new front or rear word comes from the
//   RAM's registered read port and passes through S_FILL before the output.
//   Throughput: pushes and refused operations run at one per cycle while
//   results are taken; a pop that leaves entries keeps in_tready low in S_FILL.
//   The front and rear words are cached in registers, so only the one RAM
//   read after a pop sets the cost.
//   Reset (rst_n low, synchronous) empties the deque and drops any pending
//   result; RAM contents are left as they are and never read before written.
//   When the receiver stalls, the result holds in the output register and
//   in_tready drops until it is taken.
module circular_deque_top
  import cd_pkg::*;
#(
  parameter int DEPTH      = CD_DEPTH,
  parameter int DATA_WIDTH = CD_DATA_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] operation, [33:2] push_value, rest zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [31:0] popped_value, [33:32] status,
                                             // [65:34] front_value, [97:66] rear_value,
                                             // [98] is_empty, [99] is_full,
                                             // [103:100] entry_count
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [IW-1:0] step_fwd(input logic [IW-1:0] i);
    return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] step_back(input logic [IW-1:0] i);
    return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
  endfunction

  // sign extend from DATA_WIDTH, then keep the low 32 bits
  function automatic logic [FIELD_W-1:0] to_field(input logic [DATA_WIDTH-1:0] w);
    logic [63:0] t;
    t = 64'(signed'(w));
    return t[FIELD_W-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic [IW-1:0]         head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] front_r, front_nxt, rear_r, rear_nxt;
  logic [FIELD_W-1:0]    pend_popped_r, pend_popped_nxt;
  logic                  pend_front_r, pend_front_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]    out_popped_r, out_front_r, out_rear_r;
  status_t               out_status_r;
  logic                  out_empty_r, out_full_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic                  load_out;
  logic [FIELD_W-1:0]    res_popped, res_front, res_rear;
  status_t               res_status;

  logic                  we;
  logic [IW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  logic                  in_fire, is_full, is_empty;
  op_t                   op;

  assign op        = op_t'(in_tdata[1:0]);
  assign wdata     = DATA_WIDTH'(in_tdata[33:2]);
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);

  cd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    front_nxt       = front_r;
    rear_nxt        = rear_r;
    pend_popped_nxt = pend_popped_r;
    pend_front_nxt  = pend_front_r;
    we              = 1'b0;
    waddr           = head_r;
    raddr           = head_r;
    load_out        = 1'b0;
    res_popped      = '0;
    res_status      = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              load_out = 1'b1;
              if (is_full) begin
                res_status = ST_OVERFLOW;
              end else begin
                we        = 1'b1;
                count_nxt = count_r + 1'b1;
                if (is_empty) begin
                  head_nxt  = '0;
                  tail_nxt  = '0;
                  waddr     = '0;
                  front_nxt = wdata;
                  rear_nxt  = wdata;
                end else if (op == OP_PUSH_FRONT) begin
                  head_nxt  = step_back(head_r);
                  waddr     = head_nxt;
                  front_nxt = wdata;
                end else begin
                  tail_nxt  = step_fwd(tail_r);
                  waddr     = tail_nxt;
                  rear_nxt  = wdata;
                end
              end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
              if (is_empty) begin
                load_out   = 1'b1;
                res_status = ST_UNDERFLOW;
              end else begin
                res_popped = (op == OP_POP_FRONT) ? to_field(front_r) : to_field(rear_r);
                count_nxt  = count_r - 1'b1;
                if (count_r == CW'(1)) begin
                  load_out = 1'b1;
                  head_nxt = '0;
                  tail_nxt = '0;
                end else begin
                  // new end word comes back from the RAM next cycle
                  pend_popped_nxt = res_popped;
                  pend_front_nxt  = (op == OP_POP_FRONT);
                  state_nxt       = S_FILL;
                  if (op == OP_POP_FRONT) begin
                    head_nxt = step_fwd(head_r);
                    raddr    = head_nxt;
                  end else begin
                    tail_nxt = step_back(tail_r);
                    raddr    = tail_nxt;
                  end
                end
              end
            end
            default: begin
              load_out = 1'b0;
            end
          endcase
        end
      end
      S_FILL: begin
        load_out   = 1'b1;
        res_popped = pend_popped_r;
        if (pend_front_r) begin
          front_nxt = rdata;
        end else begin
          rear_nxt = rdata;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res_front = (count_nxt == '0) ? '1 : to_field(front_nxt);
    res_rear  = (count_nxt == '0) ? '1 : to_field(rear_nxt);

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r       <= front_nxt;
    rear_r        <= rear_nxt;
    pend_popped_r <= pend_popped_nxt;
    pend_front_r  <= pend_front_nxt;
    if (load_out) begin
      out_popped_r <= res_popped;
      out_status_r <= res_status;
      out_front_r  <= res_front;
      out_rear_r   <= res_rear;
      out_empty_r  <= (count_nxt == '0);
      out_full_r   <= (count_nxt == CW'(DEPTH));
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_full_r, out_empty_r, out_rear_r, out_front_r,
                       out_status_r, out_popped_r};

endmodule
